// File: src/mpa_pkg.sv
// Package for the motion packet accumulator: widths, byte positions, result kinds
// and the request and result structures shared by the front, queue and back modules.
// Depends on nothing.
package mpa_pkg;

    localparam int PACKET_BYTES = 12;
    localparam int POS_W        = 4;
    localparam int PKT_W        = 8;
    localparam int CFG_W        = 8;
    localparam int BYTE_W       = 8;
    localparam int SUM_W        = 16;
    localparam int ACC_W        = 32;
    localparam int SUMV_W       = ACC_W + 1;
    localparam int QUAL_W       = 8;
    localparam int SHUT_W       = 17;
    localparam int VEL_W        = 48;
    localparam int LANES        = 4;
    localparam int LANE_W       = 2;
    localparam int TURN_SHIFT   = 14;

    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = 2;
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = 2;

    localparam logic [CFG_W-1:0]        CFG_RESET    = 8'd10;
    localparam logic signed [VEL_W-1:0] FWD_COEF_Q15 = 23170;

    localparam logic CMD_LINK_BYTE = 1'b0;
    localparam logic CMD_HOST_READ = 1'b1;

    localparam logic [LANE_W-1:0] LANE_AX = 2'd0;
    localparam logic [LANE_W-1:0] LANE_AY = 2'd1;
    localparam logic [LANE_W-1:0] LANE_BX = 2'd2;
    localparam logic [LANE_W-1:0] LANE_BY = 2'd3;

    localparam logic [POS_W-1:0] POS_SYNC      = 4'd0;
    localparam logic [POS_W-1:0] POS_DELTA_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_DELTA_HI  = 4'd5;
    localparam logic [POS_W-1:0] POS_QUAL_A    = 4'd6;
    localparam logic [POS_W-1:0] POS_QUAL_B    = 4'd7;
    localparam logic [POS_W-1:0] POS_SHUT_A_HI = 4'd8;
    localparam logic [POS_W-1:0] POS_SHUT_A_LO = 4'd9;
    localparam logic [POS_W-1:0] POS_SHUT_B_HI = 4'd10;
    localparam logic [POS_W-1:0] POS_SHUT_B_LO = 4'd11;

    typedef enum logic [1:0] {
        KIND_CHUNK_OK  = 2'd0,
        KIND_CHUNK_BAD = 2'd1,
        KIND_HOST_READ = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [LANES-1:0][SUM_W-1:0]  sums;
        logic [1:0][QUAL_W-1:0]       quality;
        logic [1:0][SHUT_W-1:0]       shutter;
    } t_cmd;

    typedef struct packed {
        t_kind                        kind;
        logic [VEL_W-1:0]             vel_forward;
        logic [VEL_W-1:0]             vel_side;
        logic [VEL_W-1:0]             vel_turn;
        logic [LANES-1:0][ACC_W-1:0]  raw;
        logic [1:0][QUAL_W-1:0]       quality;
        logic [1:0][SHUT_W-1:0]       shutter;
    } t_result;

endpackage

// File: src/mpa_front.sv
// Front part: parses link bytes into packets and chunks and issues one request per
// finished chunk or host read. Holds the chunk size register.
// Depends on mpa_pkg.
module mpa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_cmd,
    input  logic [mpa_pkg::BYTE_W-1:0]  i_link_byte,
    input  logic                        i_cfg_wr_en,
    input  logic [mpa_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output mpa_pkg::t_cmd               o_q_data
);

    logic [mpa_pkg::CFG_W-1:0]                          r_chunk_packets;
    logic [mpa_pkg::POS_W-1:0]                          r_pos, n_pos;
    logic [mpa_pkg::PKT_W-1:0]                          r_pkt, n_pkt;
    logic                                               r_ok, n_ok;
    logic [mpa_pkg::LANES-1:0][mpa_pkg::SUM_W-1:0]      r_sums, n_sums;
    logic [1:0][mpa_pkg::QUAL_W-1:0]                    r_pend_q, n_pend_q;
    logic [1:0][mpa_pkg::SHUT_W-1:0]                    r_pend_s, n_pend_s;
    logic [mpa_pkg::BYTE_W-1:0]                         r_shut_hi, n_shut_hi;

    logic                                               accept;
    logic [mpa_pkg::PKT_W-1:0]                          pkt_next;
    logic [mpa_pkg::PKT_W-1:0]                          limit;
    logic [mpa_pkg::LANE_W-1:0]                         lane;
    logic [mpa_pkg::SUM_W-1:0]                          delta;
    logic [mpa_pkg::SHUT_W-1:0]                         shut_word;

    assign accept    = i_push && !i_q_full;
    assign limit     = (r_chunk_packets == '0) ? mpa_pkg::CFG_W'(1) : r_chunk_packets;
    assign pkt_next  = r_pkt + mpa_pkg::PKT_W'(1);
    assign lane      = mpa_pkg::LANE_W'(r_pos - mpa_pkg::POS_DELTA_LO);
    assign delta     = {{(mpa_pkg::SUM_W-mpa_pkg::BYTE_W){~i_link_byte[7]}},
                        ~i_link_byte[7], i_link_byte[6:0]};
    assign shut_word = {({1'b0, r_shut_hi} - 9'd1), i_link_byte};

    always_comb begin
        n_pos     = r_pos;
        n_pkt     = r_pkt;
        n_ok      = r_ok;
        n_sums    = r_sums;
        n_pend_q  = r_pend_q;
        n_pend_s  = r_pend_s;
        n_shut_hi = r_shut_hi;
        o_q_push  = 1'b0;
        o_q_data  = '0;
        if (accept) begin
            if (i_cmd == mpa_pkg::CMD_HOST_READ) begin
                o_q_push      = 1'b1;
                o_q_data.kind = mpa_pkg::KIND_HOST_READ;
            end else begin
                if (r_pos == mpa_pkg::POS_SYNC && i_link_byte != '0) begin
                    n_ok = 1'b0;
                end
                if (r_pos >= mpa_pkg::POS_DELTA_LO && r_pos <= mpa_pkg::POS_DELTA_HI) begin
                    n_sums[lane] = r_sums[lane] + delta;
                end
                if (r_pkt == '0) begin
                    case (r_pos)
                        mpa_pkg::POS_QUAL_A:    n_pend_q[0] = i_link_byte;
                        mpa_pkg::POS_QUAL_B:    n_pend_q[1] = i_link_byte;
                        mpa_pkg::POS_SHUT_A_HI: n_shut_hi   = i_link_byte;
                        mpa_pkg::POS_SHUT_B_HI: n_shut_hi   = i_link_byte;
                        mpa_pkg::POS_SHUT_A_LO: n_pend_s[0] = shut_word;
                        mpa_pkg::POS_SHUT_B_LO: n_pend_s[1] = shut_word;
                        default: ;
                    endcase
                end
                if (r_pos == mpa_pkg::POS_SHUT_B_LO) begin
                    n_pos = '0;
                    if (pkt_next == '0 || pkt_next >= limit) begin
                        o_q_push         = 1'b1;
                        o_q_data.kind    = n_ok ? mpa_pkg::KIND_CHUNK_OK
                                                : mpa_pkg::KIND_CHUNK_BAD;
                        o_q_data.sums    = n_sums;
                        o_q_data.quality = n_pend_q;
                        o_q_data.shutter = n_pend_s;
                        n_pkt            = '0;
                        n_ok             = 1'b1;
                        n_sums           = '0;
                    end else begin
                        n_pkt = pkt_next;
                    end
                end else begin
                    n_pos = r_pos + mpa_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_packets <= mpa_pkg::CFG_RESET;
            r_pos           <= '0;
            r_pkt           <= '0;
            r_ok            <= 1'b1;
            r_sums          <= '0;
            r_pend_q        <= '0;
            r_pend_s        <= '0;
            r_shut_hi       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_chunk_packets <= i_cfg_wr_data;
            end
            r_pos     <= n_pos;
            r_pkt     <= n_pkt;
            r_ok      <= n_ok;
            r_sums    <= n_sums;
            r_pend_q  <= n_pend_q;
            r_pend_s  <= n_pend_s;
            r_shut_hi <= n_shut_hi;
        end
    end

    a_pos_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mpa_pkg::POS_SHUT_B_LO)
        else $error("Byte position has left the packet.");

endmodule

// File: src/mpa_cmd_queue.sv
// Short request queue between the front and back parts, so that each can stall
// on its own. Depends on mpa_pkg.
module mpa_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpa_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mpa_pkg::t_cmd   o_data
);

    mpa_pkg::t_cmd                  r_mem [mpa_pkg::CMD_DEPTH];
    logic [mpa_pkg::CMD_PTR_W-1:0]  r_wr_ptr;
    logic [mpa_pkg::CMD_PTR_W-1:0]  r_rd_ptr;
    logic [mpa_pkg::CMD_PTR_W:0]    r_count;

    assign o_full  = (r_count == (mpa_pkg::CMD_PTR_W+1)'(mpa_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + mpa_pkg::CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + mpa_pkg::CMD_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (mpa_pkg::CMD_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (mpa_pkg::CMD_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Request written into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Request taken from an empty queue.");

endmodule

// File: src/mpa_back.sv
// Back part: applies requests to the saturating accumulators and latches, forms
// the velocities and holds finished results in a small output queue.
// Depends on mpa_pkg.
module mpa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  mpa_pkg::t_cmd       i_cmd_data,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output mpa_pkg::t_result    o_head
);

    logic [mpa_pkg::LANES-1:0][mpa_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [1:0][mpa_pkg::QUAL_W-1:0]                r_qual, n_qual;
    logic [1:0][mpa_pkg::SHUT_W-1:0]                r_shut, n_shut;

    logic                                           r_a_valid;
    mpa_pkg::t_kind                                 r_a_kind, n_a_kind;
    logic [mpa_pkg::LANES-1:0][mpa_pkg::ACC_W-1:0]  r_a_raw, n_a_raw;
    logic [mpa_pkg::SUMV_W-1:0]                     r_a_sum_f, n_a_sum_f;
    logic [mpa_pkg::SUMV_W-1:0]                     r_a_sum_s, n_a_sum_s;
    logic [mpa_pkg::SUMV_W-1:0]                     r_a_sum_t, n_a_sum_t;
    logic [1:0][mpa_pkg::QUAL_W-1:0]                r_a_qual;
    logic [1:0][mpa_pkg::SHUT_W-1:0]                r_a_shut;

    mpa_pkg::t_result                               r_out_mem [mpa_pkg::OUT_DEPTH];
    logic [mpa_pkg::OUT_PTR_W-1:0]                  r_wr_ptr;
    logic [mpa_pkg::OUT_PTR_W-1:0]                  r_rd_ptr;
    logic [mpa_pkg::OUT_PTR_W:0]                    r_out_cnt;

    logic                                           take;
    logic                                           out_pop;
    logic [mpa_pkg::OUT_PTR_W+1:0]                  committed;
    logic [mpa_pkg::SUMV_W-1:0]                     ext_ax, ext_ay, ext_bx, ext_by;
    logic signed [mpa_pkg::VEL_W-1:0]               wide_f, wide_s, wide_t;
    mpa_pkg::t_result                               new_result;

    function automatic logic [mpa_pkg::ACC_W-1:0] sat_add(
        input logic [mpa_pkg::ACC_W-1:0] acc,
        input logic [mpa_pkg::SUM_W-1:0] d
    );
        logic [mpa_pkg::ACC_W:0] s;
        logic [mpa_pkg::ACC_W-1:0] res;
        s = {acc[mpa_pkg::ACC_W-1], acc}
            + {{(mpa_pkg::ACC_W+1-mpa_pkg::SUM_W){d[mpa_pkg::SUM_W-1]}}, d};
        if (s[mpa_pkg::ACC_W] != s[mpa_pkg::ACC_W-1]) begin
            res = s[mpa_pkg::ACC_W] ? {1'b1, {(mpa_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(mpa_pkg::ACC_W-1){1'b1}}};
        end else begin
            res = s[mpa_pkg::ACC_W-1:0];
        end
        return res;
    endfunction

    assign committed = {1'b0, r_out_cnt} + {{(mpa_pkg::OUT_PTR_W+1){1'b0}}, r_a_valid};
    assign take      = !i_cmd_empty
                       && (committed < (mpa_pkg::OUT_PTR_W+2)'(mpa_pkg::OUT_DEPTH));
    assign o_cmd_pop = take;

    assign ext_ax = {r_acc[mpa_pkg::LANE_AX][mpa_pkg::ACC_W-1], r_acc[mpa_pkg::LANE_AX]};
    assign ext_ay = {r_acc[mpa_pkg::LANE_AY][mpa_pkg::ACC_W-1], r_acc[mpa_pkg::LANE_AY]};
    assign ext_bx = {r_acc[mpa_pkg::LANE_BX][mpa_pkg::ACC_W-1], r_acc[mpa_pkg::LANE_BX]};
    assign ext_by = {r_acc[mpa_pkg::LANE_BY][mpa_pkg::ACC_W-1], r_acc[mpa_pkg::LANE_BY]};

    always_comb begin
        n_acc     = r_acc;
        n_qual    = r_qual;
        n_shut    = r_shut;
        n_a_kind  = i_cmd_data.kind;
        n_a_raw   = '0;
        n_a_sum_f = '0;
        n_a_sum_s = '0;
        n_a_sum_t = '0;
        case (i_cmd_data.kind)
            mpa_pkg::KIND_CHUNK_OK: begin
                for (int i = 0; i < mpa_pkg::LANES; i++) begin
                    n_acc[i] = sat_add(r_acc[i], i_cmd_data.sums[i]);
                end
                n_qual = i_cmd_data.quality;
                n_shut = i_cmd_data.shutter;
            end
            mpa_pkg::KIND_HOST_READ: begin
                n_a_raw   = r_acc;
                n_a_sum_f = ext_ay + ext_by;
                n_a_sum_s = ext_ay - ext_by;
                n_a_sum_t = ext_ax + ext_bx;
                n_acc     = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_qual    <= '0;
            r_shut    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= take;
            if (take) begin
                r_acc  <= n_acc;
                r_qual <= n_qual;
                r_shut <= n_shut;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_kind  <= n_a_kind;
            r_a_raw   <= n_a_raw;
            r_a_sum_f <= n_a_sum_f;
            r_a_sum_s <= n_a_sum_s;
            r_a_sum_t <= n_a_sum_t;
            r_a_qual  <= n_qual;
            r_a_shut  <= n_shut;
        end
    end

    // Velocity stage: the products are exact in the result width.
    assign wide_f = {{(mpa_pkg::VEL_W-mpa_pkg::SUMV_W){r_a_sum_f[mpa_pkg::ACC_W]}}, r_a_sum_f};
    assign wide_s = {{(mpa_pkg::VEL_W-mpa_pkg::SUMV_W){r_a_sum_s[mpa_pkg::ACC_W]}}, r_a_sum_s};
    assign wide_t = {{(mpa_pkg::VEL_W-mpa_pkg::SUMV_W){r_a_sum_t[mpa_pkg::ACC_W]}}, r_a_sum_t};

    always_comb begin
        new_result.kind        = r_a_kind;
        new_result.vel_forward = wide_f * mpa_pkg::FWD_COEF_Q15;
        new_result.vel_side    = wide_s * mpa_pkg::FWD_COEF_Q15;
        new_result.vel_turn    = wide_t <<< mpa_pkg::TURN_SHIFT;
        new_result.raw         = r_a_raw;
        new_result.quality     = r_a_qual;
        new_result.shutter     = r_a_shut;
    end

    assign out_pop = i_pop && !o_empty;
    assign o_empty = (r_out_cnt == '0);
    assign o_head  = r_out_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_out_mem[r_wr_ptr] <= new_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (r_a_valid) begin
                r_wr_ptr <= r_wr_ptr + mpa_pkg::OUT_PTR_W'(1);
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + mpa_pkg::OUT_PTR_W'(1);
            end
            case ({r_a_valid, out_pop})
                2'b10:   r_out_cnt <= r_out_cnt + (mpa_pkg::OUT_PTR_W+1)'(1);
                2'b01:   r_out_cnt <= r_out_cnt - (mpa_pkg::OUT_PTR_W+1)'(1);
                default: r_out_cnt <= r_out_cnt;
            endcase
        end
    end

    a_room_for_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_out_cnt < (mpa_pkg::OUT_PTR_W+1)'(mpa_pkg::OUT_DEPTH)))
        else $error("Result reached a full output queue.");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd_data.kind == mpa_pkg::KIND_HOST_READ) |=> (r_acc == '0))
        else $error("Host read did not clear the accumulators.");

endmodule

// File: src/motion_packet_accumulator.sv
// Throughput: one link byte or host read request accepted per cycle while full is low.
// Path: the byte or request that causes a result passes through the request queue,
// the accumulate stage and the velocity stage into the output queue.
// full rises when the four-entry request queue is full, as the back part waits for room.
// Reset (synchronous, active low) empties both queues, clears accumulators and latches,
// and sets the chunk size to ten packets.
module motion_packet_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_cmd,
    input  logic [mpa_pkg::BYTE_W-1:0]          i_link_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          o_kind,
    output logic signed [mpa_pkg::VEL_W-1:0]    o_vel_forward,
    output logic signed [mpa_pkg::VEL_W-1:0]    o_vel_side,
    output logic signed [mpa_pkg::VEL_W-1:0]    o_vel_turn,
    output logic signed [mpa_pkg::ACC_W-1:0]    o_raw_a_x,
    output logic signed [mpa_pkg::ACC_W-1:0]    o_raw_a_y,
    output logic signed [mpa_pkg::ACC_W-1:0]    o_raw_b_x,
    output logic signed [mpa_pkg::ACC_W-1:0]    o_raw_b_y,
    output logic [mpa_pkg::QUAL_W-1:0]          o_quality_a,
    output logic [mpa_pkg::QUAL_W-1:0]          o_quality_b,
    output logic signed [mpa_pkg::SHUT_W-1:0]   o_shutter_a,
    output logic signed [mpa_pkg::SHUT_W-1:0]   o_shutter_b,
    input  logic                                i_cfg_wr_en,
    input  logic [mpa_pkg::CFG_W-1:0]           i_cfg_wr_data
);

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    mpa_pkg::t_cmd      q_wr_data;
    mpa_pkg::t_cmd      q_rd_data;
    mpa_pkg::t_result   head;

    mpa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_cmd         (i_cmd),
        .i_link_byte   (i_link_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wr_data)
    );

    mpa_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    mpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd_data  (q_rd_data),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_head      (head)
    );

    assign full          = q_full;
    assign o_kind        = head.kind;
    assign o_vel_forward = head.vel_forward;
    assign o_vel_side    = head.vel_side;
    assign o_vel_turn    = head.vel_turn;
    assign o_raw_a_x     = head.raw[mpa_pkg::LANE_AX];
    assign o_raw_a_y     = head.raw[mpa_pkg::LANE_AY];
    assign o_raw_b_x     = head.raw[mpa_pkg::LANE_BX];
    assign o_raw_b_y     = head.raw[mpa_pkg::LANE_BY];
    assign o_quality_a   = head.quality[0];
    assign o_quality_b   = head.quality[1];
    assign o_shutter_a   = head.shutter[0];
    assign o_shutter_b   = head.shutter[1];

endmodule

// File: bench/mpa_checker.sv
`timescale 1ns / 100ps
// Checker for the motion packet accumulator: watches the request, result and register ports,
// predicts every result from its own copy of the block state and compares field by field.
// Depends on mpa_pkg only.
module mpa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic                        i_cmd,
    input  logic [mpa_pkg::BYTE_W-1:0]  i_link_byte,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic [1:0]                  i_kind,
    input  logic [mpa_pkg::VEL_W-1:0]   i_vel_forward,
    input  logic [mpa_pkg::VEL_W-1:0]   i_vel_side,
    input  logic [mpa_pkg::VEL_W-1:0]   i_vel_turn,
    input  logic [mpa_pkg::ACC_W-1:0]   i_raw_a_x,
    input  logic [mpa_pkg::ACC_W-1:0]   i_raw_a_y,
    input  logic [mpa_pkg::ACC_W-1:0]   i_raw_b_x,
    input  logic [mpa_pkg::ACC_W-1:0]   i_raw_b_y,
    input  logic [mpa_pkg::QUAL_W-1:0]  i_quality_a,
    input  logic [mpa_pkg::QUAL_W-1:0]  i_quality_b,
    input  logic [mpa_pkg::SHUT_W-1:0]  i_shutter_a,
    input  logic [mpa_pkg::SHUT_W-1:0]  i_shutter_b,
    input  logic                        i_cfg_wr_en,
    input  logic [mpa_pkg::CFG_W-1:0]   i_cfg_wr_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_chunks_ok,
    output int                          o_chunks_bad,
    output int                          o_reads
);
    import mpa_pkg::*;

    localparam longint FWD_GAIN  = 23170;
    localparam longint TURN_GAIN = 16384;
    localparam longint ACC_MAX   = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN   = -ACC_MAX - 1;

    logic [POS_W-1:0]   byte_pos;
    logic [PKT_W-1:0]   pkt_count;
    logic               frame_good;
    logic [CFG_W-1:0]   packets_cfg;
    logic [BYTE_W-1:0]  shut_hi;
    int                 lane_sum [LANES];
    longint             motion [LANES];
    logic [QUAL_W-1:0]  qual_held [2];
    logic [QUAL_W-1:0]  qual_next [2];
    logic [SHUT_W-1:0]  shut_held [2];
    logic [SHUT_W-1:0]  shut_next [2];
    t_result            expected_results [$];

    function automatic t_result latched(input t_kind k);
        t_result r;
        r = '0;
        r.kind = k;
        r.quality[0] = qual_held[0];
        r.quality[1] = qual_held[1];
        r.shutter[0] = shut_held[0];
        r.shutter[1] = shut_held[1];
        return r;
    endfunction

    function automatic longint saturate(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    task automatic clear_model();
        byte_pos    = '0;
        pkt_count   = '0;
        frame_good  = 1'b1;
        packets_cfg = CFG_RESET;
        shut_hi     = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_sum[i] = 0;
            motion[i]   = 0;
        end
        for (int i = 0; i < 2; i++) begin
            qual_held[i] = '0;
            qual_next[i] = '0;
            shut_held[i] = '0;
            shut_next[i] = '0;
        end
        expected_results.delete();
    endtask

    task automatic apply_request(input logic c, input logic [BYTE_W-1:0] b);
        t_result     r;
        logic [63:0] prod;
        int          code;
        int          limit;
        if (c == CMD_HOST_READ) begin
            r = latched(KIND_HOST_READ);
            prod = (motion[LANE_AY] + motion[LANE_BY]) * FWD_GAIN;
            r.vel_forward = prod[VEL_W-1:0];
            prod = (motion[LANE_AY] - motion[LANE_BY]) * FWD_GAIN;
            r.vel_side = prod[VEL_W-1:0];
            prod = (motion[LANE_AX] + motion[LANE_BX]) * TURN_GAIN;
            r.vel_turn = prod[VEL_W-1:0];
            for (int i = 0; i < LANES; i++) begin
                prod = motion[i];
                r.raw[i] = prod[ACC_W-1:0];
                motion[i] = 0;
            end
            expected_results.push_back(r);
            return;
        end

        if (byte_pos == POS_SYNC && b != 0) frame_good = 1'b0;
        if (byte_pos >= POS_DELTA_LO && byte_pos <= POS_DELTA_HI)
            lane_sum[byte_pos - POS_DELTA_LO] += int'(b) - 128;
        code = (int'(shut_hi) - 1) * 256 + int'(b);
        if (pkt_count == 0) begin
            case (byte_pos)
                POS_QUAL_A: begin
                    qual_next[0] = b;
                end
                POS_QUAL_B: begin
                    qual_next[1] = b;
                end
                POS_SHUT_A_HI, POS_SHUT_B_HI: begin
                    shut_hi = b;
                end
                POS_SHUT_A_LO: begin
                    shut_next[0] = code[SHUT_W-1:0];
                end
                POS_SHUT_B_LO: begin
                    shut_next[1] = code[SHUT_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (byte_pos != PACKET_BYTES - 1) begin
            byte_pos = byte_pos + 1'b1;
            return;
        end
        byte_pos  = '0;
        pkt_count = pkt_count + 1'b1;
        limit = (packets_cfg == 0) ? 1 : int'(packets_cfg);
        if (pkt_count != 0 && int'(pkt_count) < limit) return;

        if (frame_good) begin
            for (int i = 0; i < LANES; i++) motion[i] = saturate(motion[i] + lane_sum[i]);
            for (int i = 0; i < 2; i++) begin
                qual_held[i] = qual_next[i];
                shut_held[i] = shut_next[i];
            end
            expected_results.push_back(latched(KIND_CHUNK_OK));
        end else begin
            expected_results.push_back(latched(KIND_CHUNK_BAD));
        end
        pkt_count  = '0;
        frame_good = 1'b1;
        for (int i = 0; i < LANES; i++) lane_sum[i] = 0;
    endtask

    task automatic compare_field(input string name, input logic [VEL_W-1:0] want,
                                 input logic [VEL_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("kind mismatch: expected no result, got kind %0d", i_kind);
            o_fail_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", VEL_W'(want.kind), VEL_W'(i_kind));
        compare_field("vel_forward", want.vel_forward, i_vel_forward);
        compare_field("vel_side", want.vel_side, i_vel_side);
        compare_field("vel_turn", want.vel_turn, i_vel_turn);
        compare_field("raw_a_x", VEL_W'(want.raw[LANE_AX]), VEL_W'(i_raw_a_x));
        compare_field("raw_a_y", VEL_W'(want.raw[LANE_AY]), VEL_W'(i_raw_a_y));
        compare_field("raw_b_x", VEL_W'(want.raw[LANE_BX]), VEL_W'(i_raw_b_x));
        compare_field("raw_b_y", VEL_W'(want.raw[LANE_BY]), VEL_W'(i_raw_b_y));
        compare_field("quality_a", VEL_W'(want.quality[0]), VEL_W'(i_quality_a));
        compare_field("quality_b", VEL_W'(want.quality[1]), VEL_W'(i_quality_b));
        compare_field("shutter_a", VEL_W'(want.shutter[0]), VEL_W'(i_shutter_a));
        compare_field("shutter_b", VEL_W'(want.shutter[1]), VEL_W'(i_shutter_b));
        case (want.kind)
            KIND_CHUNK_OK: begin
                o_chunks_ok++;
            end
            KIND_CHUNK_BAD: begin
                o_chunks_bad++;
            end
            default: begin
                o_reads++;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            o_fail_count = 0;
            o_chunks_ok  = 0;
            o_chunks_bad = 0;
            o_reads      = 0;
        end else begin
            if (i_pop && !i_empty) check_result();
            if (i_cfg_wr_en) packets_cfg = i_cfg_wr_data;
            if (i_push && !i_full) apply_request(i_cmd, i_link_byte);
        end
        o_pending = expected_results.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the motion packet accumulator bench: clock, reset, request stimulus and the verdict.
// Depends on mpa_pkg, motion_packet_accumulator and the mpa_checker module.
module testbench;
    import mpa_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_REQUESTS = 850;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       cmd;
    logic [BYTE_W-1:0]          link_byte;
    logic                       empty;
    logic                       pop;
    logic [1:0]                 kind;
    logic signed [VEL_W-1:0]    vel_forward;
    logic signed [VEL_W-1:0]    vel_side;
    logic signed [VEL_W-1:0]    vel_turn;
    logic signed [ACC_W-1:0]    raw_a_x;
    logic signed [ACC_W-1:0]    raw_a_y;
    logic signed [ACC_W-1:0]    raw_b_x;
    logic signed [ACC_W-1:0]    raw_b_y;
    logic [QUAL_W-1:0]          quality_a;
    logic [QUAL_W-1:0]          quality_b;
    logic signed [SHUT_W-1:0]   shutter_a;
    logic signed [SHUT_W-1:0]   shutter_b;
    logic                       cfg_wr_en;
    logic [CFG_W-1:0]           cfg_wr_data;

    int fails;
    int pending;
    int chunks_ok;
    int chunks_bad;
    int reads;
    int sent;
    int cycles;
    bit calm;

    motion_packet_accumulator u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (cmd),
        .i_link_byte    (link_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (kind),
        .o_vel_forward  (vel_forward),
        .o_vel_side     (vel_side),
        .o_vel_turn     (vel_turn),
        .o_raw_a_x      (raw_a_x),
        .o_raw_a_y      (raw_a_y),
        .o_raw_b_x      (raw_b_x),
        .o_raw_b_y      (raw_b_y),
        .o_quality_a    (quality_a),
        .o_quality_b    (quality_b),
        .o_shutter_a    (shutter_a),
        .o_shutter_b    (shutter_b),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    mpa_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_cmd          (cmd),
        .i_link_byte    (link_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (kind),
        .i_vel_forward  (vel_forward),
        .i_vel_side     (vel_side),
        .i_vel_turn     (vel_turn),
        .i_raw_a_x      (raw_a_x),
        .i_raw_a_y      (raw_a_y),
        .i_raw_b_x      (raw_b_x),
        .i_raw_b_y      (raw_b_y),
        .i_quality_a    (quality_a),
        .i_quality_b    (quality_b),
        .i_shutter_a    (shutter_a),
        .i_shutter_b    (shutter_b),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_fail_count   (fails),
        .o_pending      (pending),
        .o_chunks_ok    (chunks_ok),
        .o_chunks_bad   (chunks_bad),
        .o_reads        (reads)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            pop <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    function automatic logic [PACKET_BYTES-1:0][BYTE_W-1:0] make_frame(input logic [7:0] sync);
        logic [PACKET_BYTES-1:0][BYTE_W-1:0] p;
        for (int i = 0; i < PACKET_BYTES; i++) p[i] = BYTE_W'($urandom_range(0, 255));
        p[0] = sync;
        return p;
    endfunction

    task automatic send_req(input logic c, input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < 12) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        cmd       <= c;
        link_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_frame(input logic [PACKET_BYTES-1:0][BYTE_W-1:0] p);
        for (int i = 0; i < PACKET_BYTES; i++) send_req(CMD_LINK_BYTE, p[i]);
    endtask

    // Holds the request side until every outstanding result has been taken and the
    // pipeline has had time to swallow bytes that cause no result.
    task automatic settle();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_chunk(input logic [CFG_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [PACKET_BYTES-1:0][BYTE_W-1:0] frame;
        int pick;
        int start;
        rst_n       = 1'b0;
        push        = 1'b0;
        cmd         = CMD_LINK_BYTE;
        link_byte   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        calm        = 1'b0;
        sent        = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_req(CMD_HOST_READ, 8'hFF);
        repeat (10) send_frame(make_frame(8'h00));

        set_chunk(8'd0);
        frame = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
        send_frame(frame);
        send_req(CMD_HOST_READ, 8'h00);
        frame    = ~frame;
        frame[0] = 8'h00;
        for (int i = 0; i < 5; i++) send_req(CMD_LINK_BYTE, frame[i]);
        send_req(CMD_HOST_READ, 8'hA5);
        for (int i = 5; i < PACKET_BYTES; i++) send_req(CMD_LINK_BYTE, frame[i]);
        send_frame(make_frame(8'hFF));
        send_req(CMD_HOST_READ, 8'h5A);

        set_chunk(8'd48);
        repeat (3) send_frame(make_frame(8'h00));
        set_chunk(8'd2);
        send_frame(make_frame(8'h00));

        set_chunk(8'd24);
        repeat (24) send_frame(make_frame(8'h00));
        send_req(CMD_HOST_READ, BYTE_W'($urandom_range(0, 255)));

        set_chunk(8'd1);
        start = sent;
        while (sent - start < RANDOM_REQUESTS) begin
            calm = (sent - start >= 500) && (sent - start < 800);
            pick = $urandom_range(0, 99);
            if (pick < 74) begin
                send_frame(make_frame(8'h00));
            end else if (pick < 82) begin
                send_frame(make_frame(BYTE_W'($urandom_range(1, 255))));
            end else if (pick < 90) begin
                send_req(CMD_HOST_READ, BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                send_frame(make_frame(BYTE_W'($urandom_range(0, 255))));
            end else if (pick < 98) begin
                set_chunk(CFG_W'($urandom_range(0, 4)));
            end else begin
                settle();
            end
        end
        calm = 1'b0;
        send_req(CMD_HOST_READ, BYTE_W'($urandom_range(0, 255)));
        settle();

        $display("Sent %0d requests; checked %0d accepted chunks, %0d malformed chunks, %0d reads.",
                 sent, chunks_ok, chunks_bad, reads);
        $display("Chunk sizes from 0 up to 48 were used, including size changes part-way through a chunk.");
        if (fails == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
